// ===== hdl/gbuf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gbuf_pkg;

   // Command codes carried on the request channel.
   typedef enum logic [3:0] {
      FN_INSERT     = 4'd0,
      FN_DEL_L_CHAR = 4'd1,
      FN_DEL_L_WORD = 4'd2,
      FN_DEL_R_CHAR = 4'd3,
      FN_MOV_L_CHAR = 4'd4,
      FN_MOV_R_CHAR = 4'd5,
      FN_MOV_L_WORD = 4'd6,
      FN_MOV_R_WORD = 4'd7,
      FN_CLEAR      = 4'd8,
      FN_READ       = 4'd9
   } func_type;

   // Status codes returned with every result.
   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NOCHANGE  = 2'd1,
      ST_FULL      = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   // Letters, digits and underscore belong to a word.
   function automatic logic is_word_byte(input logic [7:0] c);
      logic digit;
      logic upper;
      logic lower;
      digit = (c >= 8'h30) && (c <= 8'h39);
      upper = (c >= 8'h41) && (c <= 8'h5A);
      lower = (c >= 8'h61) && (c <= 8'h7A);
      return digit || upper || lower || (c == CHAR_UNDERSCORE);
   endfunction

endpackage

`default_nettype wire

// ===== hdl/gap_buffer_line_editor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Gap buffer line editor.
// A command transaction is accepted at a rising edge where start is high and busy
// is low; req_func selects the command, req_char_in is the byte to insert and
// req_read_index is the logical position to read. Every command answers with
// exactly one result: rsp_valid is high for one cycle with the status, the byte
// read (zero otherwise), the cursor position and the content length after the
// command. The receiver cannot stall, so results are never held back.
// Insert, byte deletes, clear, out-of-range reads and unknown commands finish at
// the accept edge and answer in the next cycle; busy stays low, so a new command
// may follow at once. Byte moves and in-range reads make one pass through the
// text memory: accept, address, evaluate, and the result is registered at the
// end of evaluate; a byte move that finds no byte to cross in its direction
// answers from the address state. Word moves and the left word delete walk the
// gap edge one byte at a time, each byte through address and then evaluate of
// the registered read data. The text memory has a registered read port.
// Reset empties the buffer (cursor and length zero) and drops any command
// in flight; the text memory itself is not cleared.

module gap_buffer_line_editor #(
   parameter int unsigned CAPACITY = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [3:0] req_func,
   input  wire logic [7:0] req_char_in,
   input  wire logic [7:0] req_read_index,
   output logic            rsp_valid,
   output logic [1:0]      rsp_status,
   output logic [7:0]      rsp_char_out,
   output logic [8:0]      rsp_cursor_pos,
   output logic [8:0]      rsp_content_len
);

   import gbuf_pkg::*;

   // Pointer width holds 0..CAPACITY; address width indexes the memory.
   localparam int unsigned PW = $clog2(CAPACITY + 1);
   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned XW = (PW > 8) ? PW : 8;
   localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_ADDR = 3'b010,
      S_EVAL = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [PW-1:0]    gf_ff, gf_in;      // gap start, which is also the cursor
   logic [PW-1:0]    gp_ff, gp_in;      // first byte past the gap
   func_type         op_ff, op_in;
   logic [7:0]       idx_ff, idx_in;
   logic             skip_ff, skip_in;  // word walk is still skipping boundary bytes
   logic             moved_ff, moved_in;

   logic             rsp_valid_ff;
   status_type       rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic [8:0]       rsp_cursor_ff;
   logic [8:0]       rsp_len_ff;

   logic             done;
   logic [PW-1:0]    len_cur;
   logic [PW-1:0]    len_next;
   logic             accept;
   logic             read_in_range;
   logic [XW-1:0]    phys_x;
   logic             left_op;
   logic             single_op;
   logic             word_byte;
   logic             consume;

   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [7:0]       mem_wdata;
   logic [AW-1:0]    mem_raddr;
   logic [7:0]       mem_rdata;

   gbuf_ram #(
      .WIDTH (8),
      .DEPTH (CAPACITY)
   ) u_text (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign len_cur = gf_ff + (CAP_P - gp_ff);

   assign read_in_range = XW'(req_read_index) < XW'(len_cur);

   // Logical to physical: positions at or after the cursor sit past the gap.
   assign phys_x = (XW'(idx_ff) < XW'(gf_ff)) ? XW'(idx_ff)
                                               : XW'(idx_ff) + XW'(gp_ff - gf_ff);

   assign left_op   = (op_ff == FN_DEL_L_WORD) || (op_ff == FN_MOV_L_CHAR) ||
                      (op_ff == FN_MOV_L_WORD);
   assign single_op = (op_ff == FN_MOV_L_CHAR) || (op_ff == FN_MOV_R_CHAR);
   assign word_byte = is_word_byte(mem_rdata);
   // A word walk takes boundary bytes first, then word bytes, and stops at the
   // first boundary byte that follows a word byte.
   assign consume   = single_op || skip_ff || word_byte;

   always_comb begin
      state_in      = state_ff;
      gf_in         = gf_ff;
      gp_in         = gp_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      skip_in       = skip_ff;
      moved_in      = moved_ff;
      done          = 1'b0;
      rsp_status_in = ST_NOCHANGE;
      rsp_char_in   = 8'd0;
      mem_we        = 1'b0;
      mem_waddr     = gf_ff[AW-1:0];
      mem_wdata     = req_char_in;
      mem_raddr     = gp_ff[AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = func_type'(req_func);
               idx_in   = req_read_index;
               skip_in  = 1'b1;
               moved_in = 1'b0;
               case (req_func)
                  FN_INSERT: begin
                     done = 1'b1;
                     if (gf_ff == gp_ff) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        mem_we        = 1'b1;
                        gf_in         = gf_ff + 1'b1;
                        rsp_status_in = ST_DONE;
                     end
                  end
                  FN_DEL_L_CHAR: begin
                     done = 1'b1;
                     if (gf_ff != '0) begin
                        gf_in         = gf_ff - 1'b1;
                        rsp_status_in = ST_DONE;
                     end
                  end
                  FN_DEL_R_CHAR: begin
                     done = 1'b1;
                     if (gp_ff != CAP_P) begin
                        gp_in         = gp_ff + 1'b1;
                        rsp_status_in = ST_DONE;
                     end
                  end
                  FN_DEL_L_WORD, FN_MOV_L_CHAR, FN_MOV_R_CHAR,
                  FN_MOV_L_WORD, FN_MOV_R_WORD: begin
                     state_in = S_ADDR;
                  end
                  FN_CLEAR: begin
                     done          = 1'b1;
                     gf_in         = '0;
                     gp_in         = CAP_P;
                     rsp_status_in = ST_DONE;
                  end
                  FN_READ: begin
                     if (read_in_range) begin
                        state_in = S_ADDR;
                     end else begin
                        done          = 1'b1;
                        rsp_status_in = ST_RANGE;
                     end
                  end
                  default: begin
                     done = 1'b1;
                  end
               endcase
            end
         end

         S_ADDR: begin
            if (op_ff == FN_READ) begin
               mem_raddr = phys_x[AW-1:0];
               state_in  = S_EVAL;
            end else if (left_op) begin
               // The byte left of the cursor sits just below the gap.
               mem_raddr = AW'(gf_ff - 1'b1);
               if (gf_ff == '0) begin
                  done          = 1'b1;
                  rsp_status_in = moved_ff ? ST_DONE : ST_NOCHANGE;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_EVAL;
               end
            end else begin
               // The byte right of the cursor sits just past the gap.
               mem_raddr = gp_ff[AW-1:0];
               if (gp_ff == CAP_P) begin
                  done          = 1'b1;
                  rsp_status_in = moved_ff ? ST_DONE : ST_NOCHANGE;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_EVAL;
               end
            end
         end

         S_EVAL: begin
            mem_wdata = mem_rdata;
            if (op_ff == FN_READ) begin
               done          = 1'b1;
               rsp_status_in = ST_DONE;
               rsp_char_in   = mem_rdata;
               state_in      = S_IDLE;
            end else if (consume) begin
               moved_in = 1'b1;
               skip_in  = skip_ff && !word_byte;
               case (op_ff)
                  FN_DEL_L_WORD: begin
                     gf_in = gf_ff - 1'b1;
                  end
                  FN_MOV_L_CHAR, FN_MOV_L_WORD: begin
                     // Carry the byte across the gap to its upper edge.
                     mem_we    = 1'b1;
                     mem_waddr = AW'(gp_ff - 1'b1);
                     gf_in     = gf_ff - 1'b1;
                     gp_in     = gp_ff - 1'b1;
                  end
                  FN_MOV_R_CHAR, FN_MOV_R_WORD: begin
                     mem_we    = 1'b1;
                     mem_waddr = gf_ff[AW-1:0];
                     gf_in     = gf_ff + 1'b1;
                     gp_in     = gp_ff + 1'b1;
                  end
                  default: begin
                  end
               endcase
               if (single_op) begin
                  done          = 1'b1;
                  rsp_status_in = ST_DONE;
                  state_in      = S_IDLE;
               end else begin
                  state_in = S_ADDR;
               end
            end else begin
               done          = 1'b1;
               rsp_status_in = moved_ff ? ST_DONE : ST_NOCHANGE;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign len_next = gf_in + (CAP_P - gp_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gf_ff        <= '0;
         gp_ff        <= CAP_P;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gf_ff        <= gf_in;
         gp_ff        <= gp_in;
         rsp_valid_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      idx_ff   <= idx_in;
      skip_ff  <= skip_in;
      moved_ff <= moved_in;
      if (done) begin
         rsp_status_ff <= rsp_status_in;
         rsp_char_ff   <= rsp_char_in;
         rsp_cursor_ff <= 9'(gf_in);
         rsp_len_ff    <= 9'(len_next);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_char_out    = rsp_char_ff;
   assign rsp_cursor_pos  = rsp_cursor_ff;
   assign rsp_content_len = rsp_len_ff;

endmodule

`default_nettype wire

// ===== hdl/gbuf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gbuf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== dv/gap_buffer_line_editor_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the gap buffer line editor.
// Command transactions are driven at the falling clock edge and counted as accepted
// at the rising edge where start is high and busy is low. At that point a predictor
// applies the same command to its own copy of the text, the cursor and the gap end.
// The expected result goes into a queue. A checker samples the result ports at every
// rising edge and compares each result with the oldest queued one, field by field.

module gap_buffer_line_editor_tb;

   import gbuf_pkg::*;

   localparam int          CAPACITY     = 256;
   localparam int          CLK_PERIOD   = 4;
   localparam int          LIMIT_CYCLES = 4_000_000;
   // The slowest command walks the whole text, one byte at a time.
   localparam int          DRAIN_CYCLES = 2 * CAPACITY + 16;
   // Command codes that the block does not know and must answer without a change.
   localparam logic [3:0]  FN_FIRST_UNKNOWN = 4'hA;
   localparam logic [3:0]  FN_LAST_UNKNOWN  = 4'hF;

   typedef struct packed {
      status_type  status;
      logic [7:0]  char_out;
      logic [8:0]  cursor_pos;
      logic [8:0]  content_len;
   } edit_reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [3:0]  req_func = 4'd0;
   logic [7:0]  req_char_in = 8'd0;
   logic [7:0]  req_read_index = 8'd0;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_char_out;
   logic [8:0]  rsp_cursor_pos;
   logic [8:0]  rsp_content_len;

   // The predicted editor: the text store, the cursor (gap start) and the gap end.
   logic [7:0]  text_mem [0:CAPACITY-1];
   int unsigned cursor;
   int unsigned gap_end;

   edit_reply_type expected_replies [$];
   int          error_count = 0;
   int          cycle_count = 0;
   // Chance in percent that the sender keeps start low and waits again before a transaction.
   int          idle_pct = 0;

   gap_buffer_line_editor #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_char_in    (req_char_in),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_char_out   (rsp_char_out),
      .rsp_cursor_pos (rsp_cursor_pos),
      .rsp_content_len(rsp_content_len)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // A hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Letters, digits and underscore make up a word. Everything else is a boundary.
   function automatic bit word_char(input logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
             (c >= "a" && c <= "z") || c == CHAR_UNDERSCORE;
   endfunction

   function automatic int unsigned text_len();
      return cursor + CAPACITY - gap_end;
   endfunction

   // Reads the text by its logical position and skips over the gap.
   function automatic logic [7:0] byte_at(input int unsigned i);
      int unsigned p;
      p = (i < cursor) ? i : i + gap_end - cursor;
      return (p < CAPACITY) ? text_mem[p] : 8'h00;
   endfunction

   // Moves the gap so that it starts at the given logical position. The bytes that
   // it passes are copied across it. The copy order keeps overlapping ranges intact.
   function automatic void shift_gap(input int unsigned target);
      int unsigned n;
      int          k;
      if (target < cursor) begin
         n = cursor - target;
         for (k = int'(n) - 1; k >= 0; k--) begin
            text_mem[gap_end - n + k] = text_mem[target + k];
         end
         cursor = target;
         gap_end = gap_end - n;
      end else if (target > cursor) begin
         n = target - cursor;
         for (k = 0; k < int'(n); k++) begin
            text_mem[cursor + k] = text_mem[gap_end + k];
         end
         cursor = target;
         gap_end = gap_end + n;
      end
   endfunction

   // The start of the word left of the cursor. Boundary bytes are skipped first,
   // then the word bytes.
   function automatic int unsigned word_start_left();
      int unsigned i;
      i = cursor;
      while (i > 0 && !word_char(byte_at(i - 1))) i--;
      while (i > 0 && word_char(byte_at(i - 1))) i--;
      return i;
   endfunction

   // Applies one command to the predicted editor and returns the result that the
   // block must give for it.
   function automatic edit_reply_type apply_edit(input logic [3:0] fn, input logic [7:0] ch,
                                                 input logic [7:0] idx);
      edit_reply_type r;
      int unsigned target;
      r.status = ST_NOCHANGE;
      r.char_out = 8'h00;
      case (fn)
         FN_INSERT: begin
            if (cursor >= gap_end) begin
               r.status = ST_FULL;
            end else begin
               text_mem[cursor] = ch;
               cursor++;
               r.status = ST_DONE;
            end
         end
         FN_DEL_L_CHAR: begin
            if (cursor > 0) begin
               cursor--;
               r.status = ST_DONE;
            end
         end
         FN_DEL_L_WORD: begin
            target = word_start_left();
            if (target != cursor) begin
               cursor = target;
               r.status = ST_DONE;
            end
         end
         FN_DEL_R_CHAR: begin
            if (gap_end < CAPACITY) begin
               gap_end++;
               r.status = ST_DONE;
            end
         end
         FN_MOV_L_CHAR: begin
            if (cursor > 0) begin
               shift_gap(cursor - 1);
               r.status = ST_DONE;
            end
         end
         FN_MOV_R_CHAR: begin
            if (gap_end < CAPACITY) begin
               shift_gap(cursor + 1);
               r.status = ST_DONE;
            end
         end
         FN_MOV_L_WORD: begin
            target = word_start_left();
            if (target != cursor) begin
               shift_gap(target);
               r.status = ST_DONE;
            end
         end
         FN_MOV_R_WORD: begin
            target = cursor;
            while (target < text_len() && !word_char(byte_at(target))) target++;
            while (target < text_len() && word_char(byte_at(target))) target++;
            if (target != cursor) begin
               shift_gap(target);
               r.status = ST_DONE;
            end
         end
         FN_CLEAR: begin
            cursor = 0;
            gap_end = CAPACITY;
            r.status = ST_DONE;
         end
         FN_READ: begin
            if (idx < text_len()) begin
               r.char_out = byte_at(32'(idx));
               r.status = ST_DONE;
            end else begin
               r.status = ST_RANGE;
            end
         end
         default: begin
         end
      endcase
      r.cursor_pos = 9'(cursor);
      r.content_len = 9'(text_len());
      return r;
   endfunction

   // Text bytes are biased toward words and spaces so that word commands have real
   // words to walk over. A quarter of them are arbitrary bytes.
   function automatic logic [7:0] pick_text_byte();
      int unsigned roll;
      logic [7:0]  c;
      roll = $urandom_range(99);
      if (roll < 30) c = 8'("a" + $urandom_range(25));
      else if (roll < 40) c = 8'("A" + $urandom_range(25));
      else if (roll < 50) c = 8'("0" + $urandom_range(9));
      else if (roll < 55) c = CHAR_UNDERSCORE;
      else if (roll < 75) c = " ";
      else c = 8'($urandom_range(255));
      return c;
   endfunction

   // Sends one command transaction and records the expected result once the block
   // accepts it. Start stays high after acceptance, so back-to-back transactions
   // never lower and raise it within one time step.
   task automatic send_cmd(input logic [3:0] fn, input logic [7:0] ch, input logic [7:0] idx);
      @(negedge clock);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_func <= fn;
      req_char_in <= ch;
      req_read_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_replies.push_back(apply_edit(fn, ch, idx));
   endtask

   // One command drawn from a mix that lets the text grow slowly between clears.
   // Most reads land inside the text. Unknown codes show up now and then.
   task automatic send_random_cmd();
      int unsigned roll;
      logic [3:0]  fn;
      logic [7:0]  idx;
      roll = $urandom_range(99);
      if (roll < 40) fn = FN_INSERT;
      else if (roll < 46) fn = FN_DEL_L_CHAR;
      else if (roll < 51) fn = FN_DEL_L_WORD;
      else if (roll < 57) fn = FN_DEL_R_CHAR;
      else if (roll < 65) fn = FN_MOV_L_CHAR;
      else if (roll < 73) fn = FN_MOV_R_CHAR;
      else if (roll < 79) fn = FN_MOV_L_WORD;
      else if (roll < 85) fn = FN_MOV_R_WORD;
      else if (roll < 86) fn = FN_CLEAR;
      else if (roll < 98) fn = FN_READ;
      else fn = 4'($urandom_range(FN_LAST_UNKNOWN, FN_FIRST_UNKNOWN));
      idx = 8'($urandom_range(255));
      if (text_len() != 0 && $urandom_range(9) < 7) idx = 8'($urandom_range(text_len() - 1));
      send_cmd(fn, pick_text_byte(), idx);
   endtask

   // Every command on an empty buffer, unknown codes, clear on an empty buffer,
   // extreme bytes, then word moves and deletes across a short mixed line.
   task automatic test_edge_cases();
      idle_pct = 0;
      send_cmd(FN_DEL_L_CHAR, 8'h00, 8'h00);
      send_cmd(FN_DEL_R_CHAR, 8'h00, 8'h00);
      send_cmd(FN_MOV_L_CHAR, 8'h00, 8'h00);
      send_cmd(FN_MOV_R_CHAR, 8'h00, 8'h00);
      send_cmd(FN_MOV_L_WORD, 8'h00, 8'h00);
      send_cmd(FN_MOV_R_WORD, 8'h00, 8'h00);
      send_cmd(FN_DEL_L_WORD, 8'h00, 8'h00);
      send_cmd(FN_READ, 8'h00, 8'h00);
      send_cmd(FN_FIRST_UNKNOWN, 8'hFF, 8'hFF);
      send_cmd(FN_LAST_UNKNOWN, 8'hFF, 8'hFF);
      send_cmd(FN_CLEAR, 8'h00, 8'h00);
      send_cmd(FN_INSERT, 8'h00, 8'h00);
      send_cmd(FN_INSERT, 8'hFF, 8'h00);
      send_cmd(FN_INSERT, "a", 8'h00);
      send_cmd(FN_INSERT, CHAR_UNDERSCORE, 8'h00);
      send_cmd(FN_INSERT, "Z", 8'h00);
      send_cmd(FN_INSERT, "9", 8'h00);
      send_cmd(FN_INSERT, " ", 8'h00);
      // The cursor now sits after a trailing space. The left word move skips the
      // space and then the word; the right word move walks back over the word and
      // stops at the space.
      send_cmd(FN_MOV_L_WORD, 8'h00, 8'h00);
      send_cmd(FN_MOV_R_WORD, 8'h00, 8'h00);
      send_cmd(FN_MOV_L_CHAR, 8'h00, 8'h00);
      send_cmd(FN_DEL_R_CHAR, 8'h00, 8'h00);
      send_cmd(FN_READ, 8'h00, 8'hFF);
      send_cmd(FN_READ, 8'h00, 8'h01);
      send_cmd(FN_DEL_L_WORD, 8'h00, 8'h00);
      send_cmd(FN_CLEAR, 8'h00, 8'h00);
   endtask

   // General editing, starting from the text that the previous test left, empty or full.
   task automatic test_random_editing(input int count, input int pct);
      idle_pct = pct;
      repeat (count) send_random_cmd();
   endtask

   // Fills the buffer to capacity with inserts at a wandering cursor. Then inserts
   // are refused, the last position is read, and the full text is edited.
   task automatic test_fill_to_capacity(input int pct);
      int unsigned roll;
      idle_pct = pct;
      send_cmd(FN_CLEAR, pick_text_byte(), 8'($urandom_range(255)));
      while (text_len() < CAPACITY) begin
         roll = $urandom_range(99);
         if (roll < 85)
            send_cmd(FN_INSERT, pick_text_byte(), 8'($urandom_range(255)));
         else if (roll < 90)
            send_cmd(FN_MOV_L_CHAR, pick_text_byte(), 8'($urandom_range(255)));
         else if (roll < 94)
            send_cmd(FN_MOV_R_CHAR, pick_text_byte(), 8'($urandom_range(255)));
         else if (roll < 97)
            send_cmd(FN_MOV_L_WORD, pick_text_byte(), 8'($urandom_range(255)));
         else
            send_cmd(FN_MOV_R_WORD, pick_text_byte(), 8'($urandom_range(255)));
      end
      repeat (3) send_cmd(FN_INSERT, pick_text_byte(), 8'($urandom_range(255)));
      send_cmd(FN_READ, 8'h00, 8'hFF);
      send_cmd(FN_READ, 8'hFF, 8'h00);
      repeat (25) send_random_cmd();
   endtask

   task automatic report_mismatch(input string field, input logic [8:0] want_v,
                                  input logic [8:0] got_v);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
      error_count++;
   endtask

   // Each result is on the ports for one cycle only, so it is checked at the edge
   // that ends that cycle.
   always @(posedge clock) begin
      edit_reply_type want;
      if (!reset && rsp_valid) begin
         if (expected_replies.size() == 0) begin
            $display("%0t: result with no command outstanding, status %0h", $time,
                     rsp_status);
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 9'(want.status), 9'(rsp_status));
            if (rsp_char_out !== want.char_out)
               report_mismatch("char_out", 9'(want.char_out), 9'(rsp_char_out));
            if (rsp_cursor_pos !== want.cursor_pos)
               report_mismatch("cursor_pos", want.cursor_pos, rsp_cursor_pos);
            if (rsp_content_len !== want.content_len)
               report_mismatch("content_len", want.content_len, rsp_content_len);
         end
      end
   end

   initial begin
      // The predicted store starts at zero. The stimulus never reads a byte that was
      // not written, so this value never reaches a comparison.
      for (int k = 0; k < CAPACITY; k++) text_mem[k] = 8'h00;
      cursor = 0;
      gap_end = CAPACITY;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_cases();
      test_random_editing(250, 0);
      test_fill_to_capacity(64);
      test_random_editing(250, 64);
      test_fill_to_capacity(0);
      test_random_editing(250, 6);

      @(negedge clock);
      start <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      // Any result that shows up now is an extra one and is flagged by the checker.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
